### hdl/msaw_pkg.sv
// ---------------------------------------------------------------------------
// msaw_pkg: shared types and constants of the morphing sawtooth oscillator
// Register map, field widths, reset values and the divider status word.
// ---------------------------------------------------------------------------
package msaw_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_AMP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERTED_RAMP = 3'd4;

	// field widths
	localparam int STEP_W   = 24;
	localparam int AMP_W    = 16;
	localparam int CTRL_W   = 17;
	localparam int SAMPLE_W = 18;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RST       = 24'd0;
	localparam logic [AMP_W-1:0]  AMP_RST        = 16'd16384;
	localparam logic [CTRL_W-1:0] SPLIT_LOW_RST  = 17'd21845;
	localparam logic [CTRL_W-1:0] SPLIT_HIGH_RST = 17'd43690;

	// fixed-point constants
	localparam int AMP_FRAC   = 14;             // Q2.14 amplitude
	localparam int GAIN_FRAC  = 16;             // Q1.16 gains and ratios
	localparam int ACC_SH     = 17;             // (rect*g + comp*g) / 2 in Q0.16
	localparam logic [CTRL_W-1:0] GAIN_ONE = 17'h10000;
	localparam logic [CTRL_W:0]   CTRL_ONE = 18'h10000;
	localparam logic signed [SAMPLE_W-1:0] INV_SCALE = -18'sd16384; // -1.0 in Q2.14
	localparam int SAMPLE_MAX = 131071;
	localparam int SAMPLE_MIN = -131072;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} msaw_div_stat_t;

endpackage

### hdl/msaw_div.sv
// ---------------------------------------------------------------------------
// msaw_div: serial restoring divider
// One quotient bit per cycle; the numerator shifts out as the quotient
// shifts in. Quotient holds after done until the next start.
// ---------------------------------------------------------------------------
module msaw_div import msaw_pkg::*; #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output msaw_div_stat_t       stat,
	output logic [NUM_W-1:0]     quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] work_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic             last;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, work_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
		last  = cnt_q == CNT_W'(NUM_W - 1);
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			work_q <= {work_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = work_q;

endmodule

### hdl/morphing_sawtooth_oscillator.sv
// ---------------------------------------------------------------------------
// morphing_sawtooth_oscillator: sawtooth with rectifier/comparator morph
// A phase accumulator drives a rising or falling ramp; a shape control
// moves the output through a rectifier sweep, a crossfade and a comparator
// sweep. Zone ratios come from a serial divider, products from one shared
// multiplier.
// ---------------------------------------------------------------------------
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid, in_ready, shape_control       | in
//  output  | out_valid, out_ready, sample_out        | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
//  Each word runs the serial divider over 17 + max(SAMPLE_FRAC_BITS, 16)
//  quotient bits, then the MUL1, RECT, MUL2 and OUT steps.
//  in_ready is high only while the sequencer is idle.
//  A finished sample sits in the output register while the next word is
//  taken; the sequencer holds its last step only if that register is full.
//  Reset restores the register defaults and clears the phase; cfg_ready is
//  always high.
//
module morphing_sawtooth_oscillator import msaw_pkg::*; #(
	parameter int PHASE_BITS       = 24,
	parameter int SAMPLE_FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [CTRL_W-1:0]           shape_control,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [SAMPLE_W-1:0]  sample_out,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int P      = PHASE_BITS;
	localparam int F      = SAMPLE_FRAC_BITS;
	localparam int DW     = CTRL_W + ((F > GAIN_FRAC) ? F : GAIN_FRAC);
	localparam int CW     = DW + 1;
	localparam int SW     = F + 4;
	localparam int AW     = (P + 1 > SW) ? P + 1 : SW;
	localparam int PRW    = AW + SAMPLE_W;
	localparam int SAW_SH = P + AMP_FRAC - F;

	localparam logic [F:0] ONE_THR = {1'b1, {F{1'b0}}};
	localparam logic signed [PRW-1:0] ACC_MAX = PRW'(SAMPLE_MAX);
	localparam logic signed [PRW-1:0] ACC_MIN = PRW'(SAMPLE_MIN);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_RECT = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// morph zones
	localparam logic [1:0] ZONE_RECT = 2'd0;
	localparam logic [1:0] ZONE_FADE = 2'd1;
	localparam logic [1:0] ZONE_COMP = 2'd2;

	// configuration registers
	logic [STEP_W-1:0] phase_step_q;
	logic [AMP_W-1:0]  ramp_amp_q;
	logic [CTRL_W-1:0] split_low_q;
	logic [CTRL_W-1:0] split_high_q;
	logic              inverted_q;

	// control and state
	logic [2:0]        state_q;
	logic [1:0]        zone_q;
	logic              den_zero_q;
	logic [P-1:0]      phase_q;
	logic              out_valid_q;

	// payload registers
	logic signed [PRW-1:0]      prod_q;
	logic signed [SW-1:0]       rect_q;
	logic                       comp_pos_q;
	logic [CTRL_W-1:0]          rect_gain_q;
	logic [CTRL_W-1:0]          comp_gain_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// combinational
	logic              in_fire;
	logic              out_load;
	logic [1:0]        zone_d;
	logic [CTRL_W-1:0] num_base;
	logic [DW-1:0]     num_load;
	logic [CTRL_W-1:0] den_load;
	logic [CTRL_W:0]   den_wide;
	msaw_div_stat_t    div_stat;
	logic [DW-1:0]     quo;

	logic signed [P:0]          ramp_s;
	logic signed [AW-1:0]       mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PRW-1:0]      mul_p;

	logic signed [PRW-1:0] saw_full;
	logic signed [SW-1:0]  saw;
	logic [F:0]            rect_thr;
	logic [DW-1:0]         comp_thr;
	logic signed [SW-1:0]  thr_s;
	logic [F:0]            half;
	logic signed [SW-1:0]  rect_d;
	logic                  comp_pos_d;
	logic [CTRL_W-1:0]     rect_gain_d;
	logic [CTRL_W-1:0]     comp_gain_d;

	logic signed [PRW-1:0]      cterm;
	logic signed [PRW-1:0]      sum;
	logic signed [PRW-1:0]      acc;
	logic signed [SAMPLE_W-1:0] sat;

	assign in_ready  = state_q == ST_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_RST;
			ramp_amp_q   <= AMP_RST;
			split_low_q  <= SPLIT_LOW_RST;
			split_high_q <= SPLIT_HIGH_RST;
			inverted_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PHASE_STEP:    phase_step_q <= cfg_data[STEP_W-1:0];
				CFG_RAMP_AMP:      ramp_amp_q   <= cfg_data[AMP_W-1:0];
				CFG_SPLIT_LOW:     split_low_q  <= cfg_data[CTRL_W-1:0];
				CFG_SPLIT_HIGH:    split_high_q <= cfg_data[CTRL_W-1:0];
				CFG_INVERTED_RAMP: inverted_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zone select and divider operands
	always_comb begin
		den_wide = CTRL_ONE - {1'b0, split_high_q};
		if (shape_control < split_low_q) begin
			zone_d   = ZONE_RECT;
			num_base = shape_control;
			den_load = split_low_q;
		end else if (shape_control < split_high_q) begin
			zone_d   = ZONE_FADE;
			num_base = shape_control - split_low_q;
			den_load = split_high_q - split_low_q;
		end else begin
			zone_d   = ZONE_COMP;
			num_base = shape_control - split_high_q;
			den_load = den_wide[CTRL_W-1:0];
		end
		if (zone_d == ZONE_FADE) begin
			num_load = DW'(num_base) << GAIN_FRAC;
		end else begin
			num_load = DW'(num_base) << F;
		end
	end

	msaw_div #(
		.NUM_W(DW),
		.DEN_W(CTRL_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_fire),
		.num   (num_load),
		.den   (den_load),
		.stat  (div_stat),
		.quo   (quo)
	);

	// shared multiplier: ramp scaling, then rectifier gain
	always_comb begin
		ramp_s = $signed({~phase_q[P-1], phase_q[P-2:0], 1'b0});
		if (state_q == ST_MUL1) begin
			mul_a = AW'(ramp_s);
			mul_b = inverted_q ? INV_SCALE : $signed({2'b00, ramp_amp_q});
		end else begin
			mul_a = AW'(rect_q);
			mul_b = $signed({1'b0, rect_gain_q});
		end
		mul_p = mul_a * mul_b;
	end

	// thresholds, gains, rectifier and comparator
	always_comb begin
		saw_full = prod_q >>> SAW_SH;
		saw      = saw_full[SW-1:0];
		rect_thr = ONE_THR;
		comp_thr = '0;
		case (zone_q)
			ZONE_RECT: begin
				rect_thr    = quo[F:0];
				rect_gain_d = GAIN_ONE;
				comp_gain_d = '0;
			end
			ZONE_FADE: begin
				rect_gain_d = GAIN_ONE - quo[CTRL_W-1:0];
				comp_gain_d = quo[CTRL_W-1:0];
			end
			default: begin
				comp_thr    = den_zero_q ? '0 : quo;
				rect_gain_d = '0;
				comp_gain_d = GAIN_ONE;
			end
		endcase
		thr_s      = $signed(SW'(rect_thr));
		half       = (ONE_THR - rect_thr) >> 1;
		rect_d     = ((saw <= thr_s) ? saw : saw - thr_s) + $signed(SW'(half));
		comp_pos_d = CW'(saw) > $signed({1'b0, comp_thr});
	end

	// mix, halve and saturate
	always_comb begin
		cterm = PRW'($signed({1'b0, comp_gain_q})) <<< F;
		sum   = prod_q + (comp_pos_q ? cterm : -cterm);
		acc   = sum >>> ACC_SH;
		if (acc > ACC_MAX) begin
			sat = SAMPLE_W'(ACC_MAX);
		end else if (acc < ACC_MIN) begin
			sat = SAMPLE_W'(ACC_MIN);
		end else begin
			sat = acc[SAMPLE_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zone_q      <= ZONE_RECT;
			den_zero_q  <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						zone_q     <= zone_d;
						den_zero_q <= (zone_d == ZONE_COMP) && split_high_q[CTRL_W-1];
						phase_q    <= phase_q + P'(phase_step_q);
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_RECT;
				ST_RECT: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_RECT) begin
			rect_q      <= rect_d;
			comp_pos_q  <= comp_pos_d;
			rect_gain_q <= rect_gain_d;
			comp_gain_q <= comp_gain_d;
		end
		if (out_load) begin
			sample_q <= sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	// checks
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in flight");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_div_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while the sequencer is idle");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("output word without a finished sample");

endmodule
